/* rtl/nps_pkg.sv */
// Shared constants and codes for the nearest path segment search block.
`timescale 1ns / 1ps
package nps_pkg;

    localparam int PATH_DEPTH_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 24;

    localparam int PATH_LEN_W  = 7;
    localparam int LOOKAHEAD_W = 23;
    localparam int CFG_DATA_W  = 23;
    localparam int INDEX_W     = 6;
    localparam int RATIO_FRAC  = 16;
    localparam int RATIO_W     = 32;

    localparam logic [LOOKAHEAD_W-1:0] LOOKAHEAD_RST = 23'd256;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_PATH_LENGTH = 1'b0;
    localparam logic CFG_LOOKAHEAD   = 1'b1;

endpackage

/* rtl/nps_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module nps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/nps_dist.sv */
// Euclidean distance unit: registered squares, then a bit-serial integer square root.
`timescale 1ns / 1ps
module nps_dist #(
    parameter int COORD_WIDTH = nps_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by,
    output logic                          done,
    output logic [COORD_WIDTH:0]          root
);

    import nps_pkg::*;

    localparam int MW  = COORD_WIDTH + 1;
    localparam int RW  = 2 * MW;
    localparam int RMW = MW + 3;
    localparam int CNW = $clog2(MW + 1);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_SQ   = 2'd1;
    localparam logic [1:0] P_SUM  = 2'd2;
    localparam logic [1:0] P_ROOT = 2'd3;

    logic [1:0]            phase_reg;
    logic [CNW-1:0]        cnt_reg;
    logic                  done_reg;
    logic [MW-1:0]         mx_reg, my_reg, root_reg;
    logic [RW-1:0]         sx_reg, sy_reg, rad_reg;
    logic [RMW-1:0]        rem_reg;

    logic signed [MW-1:0]  dx, dy;
    logic [RMW-1:0]        rem_shift, trial;

    assign dx = {ax[COORD_WIDTH-1], ax} - {bx[COORD_WIDTH-1], bx};
    assign dy = {ay[COORD_WIDTH-1], ay} - {by[COORD_WIDTH-1], by};

    assign rem_shift = {rem_reg[RMW-3:0], rad_reg[RW-1:RW-2]};
    assign trial     = RMW'({root_reg, 2'b01});

    assign done = done_reg;
    assign root = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        mx_reg    <= dx[MW-1] ? MW'(-dx) : MW'(dx);
                        my_reg    <= dy[MW-1] ? MW'(-dy) : MW'(dy);
                        phase_reg <= P_SQ;
                    end
                end
                P_SQ:
                begin
                    sx_reg    <= RW'(mx_reg) * RW'(mx_reg);
                    sy_reg    <= RW'(my_reg) * RW'(my_reg);
                    phase_reg <= P_SUM;
                end
                P_SUM:
                begin
                    rad_reg   <= sx_reg + sy_reg;
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= CNW'(MW - 1);
                    phase_reg <= P_ROOT;
                end
                P_ROOT:
                begin
                    rad_reg <= {rad_reg[RW-3:0], 2'b00};
                    if (rem_shift >= trial)
                    begin
                        rem_reg  <= rem_shift - trial;
                        root_reg <= {root_reg[MW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_shift;
                        root_reg <= {root_reg[MW-2:0], 1'b0};
                    end
                    if (cnt_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        phase_reg <= P_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/nps_div.sv */
// Restoring divider for the Q16.16 detour ratio, one quotient bit per cycle, saturating.
`timescale 1ns / 1ps
module nps_div #(
    parameter int COORD_WIDTH = nps_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [COORD_WIDTH+1:0]            num,
    input  logic [COORD_WIDTH:0]              den,
    output logic                              done,
    output logic [nps_pkg::RATIO_W-1:0]       quo
);

    import nps_pkg::*;

    localparam int DSW = COORD_WIDTH + 1;
    localparam int QW  = COORD_WIDTH + 2 + RATIO_FRAC;
    localparam int QXW = (QW > RATIO_W) ? QW : RATIO_W;
    localparam int CNW = $clog2(QW + 1);
    localparam logic [QXW-1:0] RMAX = QXW'(64'hFFFF_FFFF);

    logic           busy_reg, done_reg;
    logic [CNW-1:0] cnt_reg;
    logic [QW-1:0]  dvd_reg, q_reg;
    logic [DSW-1:0] den_reg, rem_reg;
    logic [DSW:0]   r;
    logic [QXW-1:0] qx;

    assign r  = {rem_reg, dvd_reg[QW-1]};
    assign qx = QXW'(q_reg);

    assign done = done_reg;
    assign quo  = (qx > RMAX) ? {RATIO_W{1'b1}} : RATIO_W'(qx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (start)
                begin
                    dvd_reg  <= {num, {RATIO_FRAC{1'b0}}};
                    den_reg  <= den;
                    rem_reg  <= '0;
                    q_reg    <= '0;
                    cnt_reg  <= CNW'(QW - 1);
                    busy_reg <= 1'b1;
                end
            end
            else
            begin
                dvd_reg <= {dvd_reg[QW-2:0], 1'b0};
                if (r >= {1'b0, den_reg})
                begin
                    rem_reg <= DSW'(r - {1'b0, den_reg});
                    q_reg   <= {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= DSW'(r);
                    q_reg   <= {q_reg[QW-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/nearest_path_segment_search_top.sv */
// Waypoint store and query sequencer for the nearest path segment search.
// A waypoint write is stored while the controller stays in idle.
// A query walks the segments one at a time through the shared bit-serial square root
// and divider units; paths shorter than two waypoints answer zero without a walk.
// Reset clears the controller and registers (path_length 0, lookahead 256); the waypoint
// memory is not cleared and holds nothing meaningful until written.
`timescale 1ns / 1ps
module nearest_path_segment_search_top #(
    parameter int PATH_DEPTH  = nps_pkg::PATH_DEPTH_DEF,
    parameter int COORD_WIDTH = nps_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [nps_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic [nps_pkg::INDEX_W-1:0]       point_index,
    input  logic signed [COORD_WIDTH-1:0]     coord_x,
    input  logic signed [COORD_WIDTH-1:0]     coord_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [nps_pkg::INDEX_W-1:0]       target_index
);

    import nps_pkg::*;

    localparam int AW  = $clog2(PATH_DEPTH);
    localparam int NW  = AW + 1;
    localparam int CW  = COORD_WIDTH;
    localparam int DSW = CW + 1;
    localparam int SMW = CW + 2;
    localparam int LW  = (DSW > LOOKAHEAD_W) ? DSW : LOOKAHEAD_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LDA  = 4'd1;
    localparam logic [3:0] S_CAPA = 4'd2;
    localparam logic [3:0] S_WDI  = 4'd3;
    localparam logic [3:0] S_LDB  = 4'd4;
    localparam logic [3:0] S_CAPB = 4'd5;
    localparam logic [3:0] S_WDJ  = 4'd6;
    localparam logic [3:0] S_WDIJ = 4'd7;
    localparam logic [3:0] S_WDIV = 4'd8;
    localparam logic [3:0] S_NEXT = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]                 state_reg;
    logic [PATH_LEN_W-1:0]      path_length_reg;
    logic [LOOKAHEAD_W-1:0]     lookahead_reg;
    logic [NW-1:0]              n_reg, seg_reg, best_end_reg, result_reg;
    logic [AW-1:0]              rd_addr_reg;
    logic                       found_reg, out_valid_reg;
    logic [RATIO_W-1:0]         best_ratio_reg;
    logic [INDEX_W-1:0]         target_reg;
    logic signed [CW-1:0]       rx_reg, ry_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic [DSW-1:0]             di_reg, dj_reg;

    logic                       accept, ram_we, more;
    logic [NW-1:0]              n_in;
    logic [2*CW-1:0]            rdata;
    logic signed [CW-1:0]       rd_x, rd_y, d_ax, d_ay, d_bx, d_by;
    logic                       dist_start, dist_done, div_done;
    logic [DSW-1:0]             dist_root;
    logic [SMW-1:0]             sum, num;
    logic [RATIO_W-1:0]         ratio;
    logic                       out_load;

    assign in_ready     = (state_reg == S_IDLE);
    assign accept       = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign target_index = target_reg;

    assign n_in = (32'(path_length_reg) > PATH_DEPTH) ? NW'(PATH_DEPTH)
                                                     : NW'(path_length_reg);

    assign ram_we = accept && (opcode == OP_WRITE) && (32'(point_index) < PATH_DEPTH);

    nps_ram #(
        .WIDTH (2 * CW),
        .DEPTH (PATH_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(point_index)),
        .wdata ({coord_x, coord_y}),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    assign rd_x = rdata[2*CW-1:CW];
    assign rd_y = rdata[CW-1:0];

    // The segment length uses both stored end points; the other distances use the robot.
    assign dist_start = (state_reg == S_CAPA) || (state_reg == S_CAPB)
                     || ((state_reg == S_WDJ) && dist_done);
    assign d_ax = (state_reg == S_WDJ) ? ax_reg : rd_x;
    assign d_ay = (state_reg == S_WDJ) ? ay_reg : rd_y;
    assign d_bx = (state_reg == S_WDJ) ? bx_reg : rx_reg;
    assign d_by = (state_reg == S_WDJ) ? by_reg : ry_reg;

    nps_dist #(
        .COORD_WIDTH (CW)
    ) u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dist_start),
        .ax    (d_ax),
        .ay    (d_ay),
        .bx    (d_bx),
        .by    (d_by),
        .done  (dist_done),
        .root  (dist_root)
    );

    assign sum = SMW'(di_reg) + SMW'(dj_reg);
    assign num = (sum > SMW'(dist_root)) ? (sum - SMW'(dist_root)) : '0;

    nps_div #(
        .COORD_WIDTH (CW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start ((state_reg == S_WDIJ) && dist_done && (dist_root != '0)),
        .num   (num),
        .den   (dist_root),
        .done  (div_done),
        .quo   (ratio)
    );

    // True while segment seg+1 exists; also tells whether the end index may advance.
    assign more = ((NW + 1)'(seg_reg) + (NW + 1)'(2)) < (NW + 1)'(n_reg);

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_length_reg <= '0;
            lookahead_reg   <= LOOKAHEAD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATH_LENGTH: path_length_reg <= cfg_data[PATH_LEN_W-1:0];
                CFG_LOOKAHEAD:   lookahead_reg   <= cfg_data[LOOKAHEAD_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
            target_reg    <= INDEX_W'(result_reg);
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            found_reg   <= 1'b0;
            rd_addr_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (opcode == OP_QUERY))
                    begin
                        rx_reg      <= coord_x;
                        ry_reg      <= coord_y;
                        n_reg       <= n_in;
                        seg_reg     <= '0;
                        found_reg   <= 1'b0;
                        rd_addr_reg <= '0;
                        if (n_in < NW'(2))
                        begin
                            result_reg <= '0;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_LDA;
                        end
                    end
                end
                S_LDA:
                begin
                    state_reg <= S_CAPA;
                end
                S_CAPA:
                begin
                    ax_reg    <= rd_x;
                    ay_reg    <= rd_y;
                    state_reg <= S_WDI;
                end
                S_WDI:
                begin
                    if (dist_done)
                    begin
                        di_reg      <= dist_root;
                        rd_addr_reg <= AW'(seg_reg + 1'b1);
                        state_reg   <= S_LDB;
                    end
                end
                S_LDB:
                begin
                    state_reg <= S_CAPB;
                end
                S_CAPB:
                begin
                    bx_reg    <= rd_x;
                    by_reg    <= rd_y;
                    state_reg <= S_WDJ;
                end
                S_WDJ:
                begin
                    if (dist_done)
                    begin
                        dj_reg    <= dist_root;
                        state_reg <= S_WDIJ;
                    end
                end
                S_WDIJ:
                begin
                    if (dist_done)
                    begin
                        state_reg <= (dist_root == '0) ? S_NEXT : S_WDIV;
                    end
                end
                S_WDIV:
                begin
                    if (div_done)
                    begin
                        if (!found_reg || (ratio < best_ratio_reg))
                        begin
                            found_reg      <= 1'b1;
                            best_ratio_reg <= ratio;
                            if ((LW'(dj_reg) < LW'(lookahead_reg)) && more)
                            begin
                                best_end_reg <= seg_reg + NW'(2);
                            end
                            else
                            begin
                                best_end_reg <= seg_reg + NW'(1);
                            end
                        end
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    ax_reg  <= bx_reg;
                    ay_reg  <= by_reg;
                    di_reg  <= dj_reg;
                    seg_reg <= seg_reg + 1'b1;
                    if (more)
                    begin
                        rd_addr_reg <= AW'(seg_reg + NW'(2));
                        state_reg   <= S_LDB;
                    end
                    else
                    begin
                        result_reg <= found_reg ? best_end_reg : (n_reg - 1'b1);
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/nps_checker.sv */
// Port-level checks for the nearest path segment search, bound to the top level.
`timescale 1ns / 1ps
module nps_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         opcode,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [nps_pkg::INDEX_W-1:0]  target_index
);

    import nps_pkg::*;

    // A stalled result must hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(target_index))
        else $error("result changed while stalled");

    // A waypoint write completes in the cycle it is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_WRITE) |=> in_ready)
        else $error("write transaction did not leave the block idle");

    // An accepted query takes the block out of idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_QUERY) |=> !in_ready)
        else $error("query transaction did not occupy the block");

    // A new result appears exactly as the block returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result raised while a query was still in progress");

endmodule

bind nearest_path_segment_search_top nps_checker u_nps_checker (.*);

/* verif/tb_nearest_path_segment_search_top.sv */
// Testbench for the nearest path segment search block: directed table, then random phases.
`timescale 1ns / 1ps
module tb_nearest_path_segment_search_top;
    import nps_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int RANDOM_ITEMS   = 1850;

    typedef struct {
        bit                      is_cfg;
        logic                    cfg_sel;
        logic [CFG_DATA_W-1:0]   cfg_val;
        logic                    op;
        logic [INDEX_W-1:0]      slot;
        logic signed [23:0]      px;
        logic signed [23:0]      py;
        int                      fixed_target;
    } step_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic                    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic                    opcode;
    logic [INDEX_W-1:0]      point_index;
    logic signed [23:0]      coord_x;
    logic signed [23:0]      coord_y;
    logic                    out_valid;
    logic                    out_ready;
    logic [INDEX_W-1:0]      target_index;

    // Shadow copy of the block's registers and waypoint memory.
    logic [PATH_LEN_W-1:0]   len_shadow;
    logic [LOOKAHEAD_W-1:0]  lookahead_shadow;
    logic signed [23:0]      wp_x [64];
    logic signed [23:0]      wp_y [64];

    logic [INDEX_W-1:0]      pending_targets[$];
    step_t                   steps[$];
    int                      error_count;
    bit                      sender_burst;
    int                      items_sent;

    nearest_path_segment_search_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .point_index  (point_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .target_index (target_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned span(input logic signed [23:0] ax,
                                             input logic signed [23:0] ay,
                                             input logic signed [23:0] bx,
                                             input logic signed [23:0] by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return int_sqrt(longint'(dx * dx) + longint'(dy * dy));
    endfunction

    function automatic logic [INDEX_W-1:0] nearest_target(input logic signed [23:0] rx,
                                                          input logic signed [23:0] ry);
        longint unsigned n;
        longint unsigned best_ratio;
        longint unsigned best_end;
        longint unsigned di;
        longint unsigned dj;
        longint unsigned dij;
        longint unsigned num;
        longint unsigned ratio;
        bit found;
        n = len_shadow;
        best_ratio = 0;
        best_end = 0;
        found = 0;
        if (n > 64) n = 64;
        if (n == 0) return '0;
        for (int i = 0; i + 1 < n; i++)
        begin
            di  = span(wp_x[i], wp_y[i], rx, ry);
            dj  = span(wp_x[i+1], wp_y[i+1], rx, ry);
            dij = span(wp_x[i], wp_y[i], wp_x[i+1], wp_y[i+1]);
            if (dij == 0) continue;
            num = (di + dj > dij) ? (di + dj - dij) : 0;
            ratio = (num << RATIO_FRAC) / dij;
            if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
            if (!found || ratio < best_ratio)
            begin
                found = 1;
                best_ratio = ratio;
                best_end = i + 1;
                if (dj < lookahead_shadow && best_end < n - 1)
                    best_end++;
            end
        end
        if (!found) best_end = n - 1;
        return best_end[INDEX_W-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_burst || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [23:0] near_coord(input logic signed [23:0] centre);
        longint v;
        if ($urandom_range(0, 19) == 0)
            return 24'($urandom);
        v = longint'(centre) + $signed($urandom_range(0, 4000)) - 2000;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    task automatic wait_idle();
        while (pending_targets.size() != 0)
            @(posedge clk);
        // Waypoint writes give no result, so let the last one settle.
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic sel, input logic [CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (sel == CFG_PATH_LENGTH)
            len_shadow = val[PATH_LEN_W-1:0];
        else
            lookahead_shadow = val[LOOKAHEAD_W-1:0];
    endtask

    task automatic send_item(input logic op, input logic [INDEX_W-1:0] slot,
                             input logic signed [23:0] px, input logic signed [23:0] py,
                             input int fixed_target);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        point_index <= slot;
        coord_x     <= px;
        coord_y     <= py;
        do @(negedge clk); while (!in_ready);
        // The transaction completes at the coming rising edge.
        if (op == OP_WRITE)
        begin
            wp_x[slot] = px;
            wp_y[slot] = py;
        end
        else if (fixed_target >= 0)
            pending_targets.insert(pending_targets.size(), fixed_target[INDEX_W-1:0]);
        else
            pending_targets.insert(pending_targets.size(), nearest_target(px, py));
        items_sent++;
        @(posedge clk);
    endtask

    function automatic void add_item(input logic op, input logic [INDEX_W-1:0] slot,
                                     input logic signed [23:0] px,
                                     input logic signed [23:0] py, input int fixed_target);
        step_t s;
        s = '{0, 1'b0, '0, op, slot, px, py, fixed_target};
        steps.insert(steps.size(), s);
    endfunction

    function automatic void add_cfg(input logic sel, input logic [CFG_DATA_W-1:0] val);
        step_t s;
        s = '{1, sel, val, OP_WRITE, '0, '0, '0, -1};
        steps.insert(steps.size(), s);
    endfunction

    // Receiver: random back-pressure with one long hold-off, and the result check.
    initial
    begin : receiver
        int cyc;
        int mode_left;
        bit steady;
        logic [INDEX_W-1:0] want;
        cyc = 0;
        mode_left = 0;
        steady = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == 30000)
            begin
                out_ready <= 1'b0;
                repeat (4000) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                steady = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (steady || $urandom_range(0, 99) < 60)
                out_ready <= 1'b1;
            else if ($urandom_range(0, 29) == 0)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b0;
            @(negedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_targets.size() == 0)
                begin
                    $error("target_index: no result expected, actual %0d", target_index);
                    error_count++;
                end
                else
                begin
                    want = pending_targets.pop_front();
                    if (target_index !== want)
                    begin
                        $error("target_index: expected %0d, actual %0d", want, target_index);
                        error_count++;
                    end
                end
            end
        end
    end

    // A long quiet stretch with no transaction on either side means the block hung.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(negedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int len;
        int n_items;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_PATH_LENGTH;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_WRITE;
        point_index = '0;
        coord_x = '0;
        coord_y = '0;
        error_count = 0;
        items_sent = 0;
        sender_burst = 0;
        len_shadow = '0;
        lookahead_shadow = LOOKAHEAD_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: an empty path answers zero.
        add_item(OP_QUERY, 6'd0, 24'sd0, 24'sd0, 0);
        foreach (steps[k])
            if (!steps[k].is_cfg)
                send_item(steps[k].op, steps[k].slot, steps[k].px, steps[k].py,
                          steps[k].fixed_target);
        steps.delete();

        // Fill every slot so that no query ever reads an unwritten waypoint.
        for (int s = 0; s < 64; s++)
            send_item(OP_WRITE, s[INDEX_W-1:0], 24'($urandom), 24'($urandom), -1);

        add_cfg(CFG_PATH_LENGTH, 23'd1);
        add_item(OP_QUERY, 6'd5, 24'sd100, -24'sd100, 0);
        add_item(OP_WRITE, 6'd0, -24'sd8388608, 24'sd8388607, -1);
        add_item(OP_WRITE, 6'd1, -24'sd8388608, 24'sd8388607, -1);
        add_cfg(CFG_PATH_LENGTH, 23'd2);
        // Zero-length only segment: the answer is the last waypoint.
        add_item(OP_QUERY, 6'd0, 24'sd0, 24'sd0, 1);
        add_item(OP_WRITE, 6'd1, 24'sd8388607, -24'sd8388608, -1);
        add_item(OP_QUERY, 6'd63, 24'sd0, 24'sd0, -1);
        add_item(OP_QUERY, 6'd0, 24'sd8388607, 24'sd8388607, -1);
        add_item(OP_QUERY, 6'd0, -24'sd8388608, -24'sd8388608, -1);
        add_item(OP_WRITE, 6'd2, 24'sd0, 24'sd0, -1);
        add_item(OP_WRITE, 6'd3, 24'sd256, 24'sd0, -1);
        add_cfg(CFG_PATH_LENGTH, 23'd4);
        add_cfg(CFG_LOOKAHEAD, 23'd0);
        add_item(OP_QUERY, 6'd0, 24'sd10, 24'sd0, -1);
        add_cfg(CFG_LOOKAHEAD, 23'h7FFFFF);
        add_item(OP_QUERY, 6'd0, 24'sd10, 24'sd0, -1);
        // A length above the memory depth is clipped to the depth.
        add_cfg(CFG_PATH_LENGTH, 23'd127);
        add_item(OP_QUERY, 6'd0, 24'sd300, 24'sd300, -1);
        add_cfg(CFG_PATH_LENGTH, 23'd64);
        add_item(OP_QUERY, 6'd0, -24'sd300, 24'sd300, -1);
        add_item(OP_WRITE, 6'd63, 24'sd1, 24'sd1, -1);
        add_cfg(CFG_LOOKAHEAD, 23'd256);
        foreach (steps[k])
        begin
            if (steps[k].is_cfg)
                write_reg(steps[k].cfg_sel, steps[k].cfg_val);
            else
                send_item(steps[k].op, steps[k].slot, steps[k].px, steps[k].py,
                          steps[k].fixed_target);
        end

        // Random phases: a path is laid down around a centre, then queried nearby.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0:       len = 64;
                1:       len = $urandom_range(65, 127);
                2:       len = 0;
                default: len = $urandom_range(1, 6);
            endcase
            write_reg(CFG_PATH_LENGTH, CFG_DATA_W'(len));
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_LOOKAHEAD, 23'd0);
                1:       write_reg(CFG_LOOKAHEAD, 23'h7FFFFF);
                2:       write_reg(CFG_LOOKAHEAD, CFG_DATA_W'($urandom));
                default: write_reg(CFG_LOOKAHEAD, CFG_DATA_W'($urandom_range(0, 3000)));
            endcase
            sender_burst = ($urandom_range(0, 3) == 0);
            cx = 24'($urandom);
            cy = 24'($urandom);
            for (int s = 0; s < len && s < 64; s++)
            begin
                // Repeat the previous point now and then to make zero-length segments.
                if (s > 0 && $urandom_range(0, 9) == 0)
                    send_item(OP_WRITE, s[INDEX_W-1:0], wp_x[s-1], wp_y[s-1], -1);
                else
                    send_item(OP_WRITE, s[INDEX_W-1:0], near_coord(cx), near_coord(cy), -1);
            end
            n_items = (len > 8) ? 3 : $urandom_range(5, 25);
            for (int k = 0; k < n_items; k++)
            begin
                if ($urandom_range(0, 9) < 2)
                    send_item(OP_WRITE, INDEX_W'($urandom), near_coord(cx), near_coord(cy),
                              -1);
                else
                    send_item(OP_QUERY, INDEX_W'($urandom), near_coord(cx), near_coord(cy),
                              -1);
            end
        end
        in_valid <= 1'b0;

        while (pending_targets.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* nearest_path_segment_search_top.f */
rtl/nps_pkg.sv
rtl/nps_ram.sv
rtl/nps_dist.sv
rtl/nps_div.sv
rtl/nearest_path_segment_search_top.sv
rtl/nps_checker.sv
verif/tb_nearest_path_segment_search_top.sv
